FILE: design/oaht_pkg.sv
// package for the open addressing hash table
// types, constants and codes used by the hash table and its testbench; no dependencies
package oaht_pkg;

  localparam int unsigned CapacityDef  = 256;
  localparam int unsigned KeyBytesDef  = 8;
  localparam int unsigned ValueBitsDef = 32;

  localparam logic [63:0] FnvBasis = 64'd14695981039346656037;
  localparam logic [63:0] FnvPrime = 64'd1099511628211;

  typedef enum logic [1:0] {
    FUNC_LOOKUP = 2'd0,
    FUNC_INSERT = 2'd1,
    FUNC_REMOVE = 2'd2,
    FUNC_CLEAR  = 2'd3
  } func_e;

  typedef enum logic [2:0] {
    RS_HIT      = 3'd0,
    RS_MISS     = 3'd1,
    RS_INSERTED = 3'd2,
    RS_UPDATED  = 3'd3,
    RS_FULL     = 3'd4,
    RS_CLEARED  = 3'd5
  } status_e;

  typedef enum logic [1:0] {
    SLOT_EMPTY = 2'd0,
    SLOT_USED  = 2'd1,
    SLOT_TOMB  = 2'd2
  } slot_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_HASH,
    ST_MUL,
    ST_DISPATCH,
    ST_RD,
    ST_WAIT,
    ST_CHECK,
    ST_INS,
    ST_CLEAR,
    ST_OUT
  } state_e;

  typedef struct packed {
    logic [1:0]  func;
    logic [63:0] key;
    logic [3:0]  key_len;
    logic [31:0] value;
  } req_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] result_value;
    logic [8:0]  entry_count;
    logic [8:0]  tombstone_count;
  } rsp_t;

endpackage

FILE: design/oaht_ram.sv
// generic single port ram with registered read
// no dependencies
module oaht_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end
endmodule

FILE: design/open_addressing_hash_table.sv
// open addressing hash table, linear probing with tombstones, fnv-1a 64 hash
// the hash takes one ST_HASH and ST_MUL pair per key byte, each probed slot passes ST_RD, ST_WAIT and ST_CHECK;
// a new key probes twice, then ST_INS writes it; clear sweeps all Capacity slots
// throughput: one request at a time, in_ready_o low until the result transfer
// reset: clears all slot states by a sweep over the Capacity slots before the first request
// depends on oaht_pkg and oaht_ram
module open_addressing_hash_table import oaht_pkg::*; #(
  parameter int unsigned Capacity  = CapacityDef,
  parameter int unsigned KeyBytes  = KeyBytesDef,
  parameter int unsigned ValueBits = ValueBitsDef
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  req_t in_data_i,
  output logic out_valid_o,
  input  logic out_ready_i,
  output rsp_t out_data_o
);
  localparam int unsigned AW = $clog2(Capacity);
  localparam int unsigned CW = AW + 1;
  localparam int unsigned SlotW = 64 + 64 + 4 + ValueBits;
  localparam logic [CW-1:0] LoadMax = CW'(Capacity - Capacity / 4);
  localparam logic [CW-1:0] CapLast = CW'(Capacity - 1);

  state_e state_q, state_d;
  logic [1:0]           func_q;
  logic [63:0]          key_q;
  logic [3:0]           len_q;
  logic [ValueBits-1:0] val_q;
  logic [63:0]          hash_q;
  logic [3:0]           byte_q;
  logic [AW-1:0]        idx_q;
  logic [CW-1:0]        cnt_q;
  logic                 pass2_q;
  logic                 tomb_vld_q;
  logic [AW-1:0]        tomb_q;
  logic [CW-1:0]        live_q, dead_q;
  rsp_t                 rsp_q;
  logic                 init_q;

  logic                 st_we, sl_we;
  logic [AW-1:0]        addr;
  logic [1:0]           st_wdata, st_rdata;
  logic [SlotW-1:0]     sl_wdata, sl_rdata;
  logic [63:0]          r_hash, r_key;
  logic [3:0]           r_len;
  logic [ValueBits-1:0] r_val;
  logic                 match;
  logic [63:0]          prod;

  assign {r_hash, r_key, r_len, r_val} = sl_rdata;
  assign match = (st_rdata == SLOT_USED) && (r_hash == hash_q) && (r_len == len_q)
                 && (r_key == key_q);
  // fnv prime is 2^40 + 0x1b3, so the multiply is a shift-and-add
  assign prod = (hash_q << 40) + (hash_q << 8) + (hash_q << 7) + (hash_q << 5)
                + (hash_q << 4) + (hash_q << 1) + hash_q;

  oaht_ram #(.Width(2), .Depth(Capacity)) u_state_ram (
    .clk_i, .we_i(st_we), .addr_i(addr), .wdata_i(st_wdata), .rdata_o(st_rdata));
  oaht_ram #(.Width(SlotW), .Depth(Capacity)) u_slot_ram (
    .clk_i, .we_i(sl_we), .addr_i(addr), .wdata_i(sl_wdata), .rdata_o(sl_rdata));

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = (state_q == ST_OUT);
  assign out_data_o  = rsp_q;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_HASH;
      end
      ST_HASH: begin
        if (func_q == FUNC_CLEAR) state_d = ST_CLEAR;
        else if (byte_q == len_q) state_d = ST_DISPATCH;
        else state_d = ST_MUL;
      end
      ST_MUL:      state_d = ST_HASH;
      ST_DISPATCH: state_d = ST_RD;
      ST_RD:       state_d = ST_WAIT;
      ST_WAIT:     state_d = ST_CHECK;
      ST_CHECK: begin
        if (st_rdata == SLOT_EMPTY || match || cnt_q == CapLast) begin
          state_d = ST_OUT;
          if (!match && !pass2_q && func_q == FUNC_INSERT && (live_q + dead_q) < LoadMax)
            state_d = ST_DISPATCH;
          else if (pass2_q && (st_rdata == SLOT_EMPTY || st_rdata == SLOT_TOMB
                               || tomb_vld_q))
            state_d = ST_INS;
        end else begin
          state_d = ST_RD;
        end
      end
      ST_INS: state_d = ST_OUT;
      ST_CLEAR: begin
        if (idx_q == AW'(Capacity - 1)) state_d = init_q ? ST_OUT : ST_IDLE;
      end
      ST_OUT: begin
        if (out_ready_i) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // ram controls
  always_comb begin
    st_we    = 1'b0;
    sl_we    = 1'b0;
    addr     = idx_q;
    st_wdata = SLOT_EMPTY;
    sl_wdata = {hash_q, key_q, len_q, val_q};
    unique case (state_q)
      ST_CLEAR: st_we = 1'b1;
      ST_CHECK: begin
        if (match && !pass2_q && func_q == FUNC_INSERT) begin
          sl_we    = 1'b1;
          sl_wdata = {r_hash, r_key, r_len, val_q};
        end else if (match && func_q == FUNC_REMOVE) begin
          st_we    = 1'b1;
          st_wdata = SLOT_TOMB;
        end
      end
      ST_INS: begin
        addr     = tomb_q;
        st_we    = 1'b1;
        sl_we    = 1'b1;
        st_wdata = SLOT_USED;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      init_q  <= 1'b0;
      idx_q   <= '0;
      live_q  <= '0;
      dead_q  <= '0;
      rsp_q   <= '0;
    end else begin
      state_q <= state_d;
      unique case (state_q)
        ST_IDLE: begin
          if (in_valid_i) begin
            init_q     <= 1'b1;
            func_q     <= in_data_i.func;
            len_q      <= (in_data_i.key_len > 4'(KeyBytes)) ? 4'(KeyBytes)
                                                           : in_data_i.key_len;
            key_q      <= in_data_i.key;
            val_q      <= ValueBits'(in_data_i.value);
            hash_q     <= FnvBasis;
            byte_q     <= '0;
            idx_q      <= '0;
            pass2_q    <= 1'b0;
          end
        end
        ST_HASH: begin
          if (byte_q == len_q) begin
            for (int i = 0; i < 8; i++) begin
              if (4'(i) >= len_q) key_q[8*i +: 8] <= 8'h00;
            end
          end else begin
            hash_q[7:0] <= hash_q[7:0] ^ key_q[8*byte_q[2:0] +: 8];
          end
        end
        ST_MUL: begin
          hash_q <= prod;
          byte_q <= byte_q + 4'd1;
        end
        ST_DISPATCH: begin
          idx_q      <= hash_q[AW-1:0];
          cnt_q      <= '0;
          tomb_vld_q <= 1'b0;
        end
        ST_CHECK: begin
          if (st_rdata == SLOT_TOMB && !tomb_vld_q) begin
            tomb_vld_q <= 1'b1;
            tomb_q     <= idx_q;
          end
          if (state_d == ST_RD) begin
            idx_q <= (idx_q == AW'(Capacity - 1)) ? '0 : idx_q + 1'b1;
            cnt_q <= cnt_q + 1'b1;
          end else if (state_d == ST_DISPATCH) begin
            pass2_q <= 1'b1;
          end else if (state_d == ST_INS) begin
            if (!(tomb_vld_q || st_rdata == SLOT_TOMB)) tomb_q <= idx_q;
          end else begin
            rsp_q.entry_count     <= 9'(live_q);
            rsp_q.tombstone_count <= 9'(dead_q);
            rsp_q.result_value    <= '0;
            rsp_q.status          <= RS_MISS;
            if (match) begin
              unique case (func_q)
                FUNC_INSERT: rsp_q.status <= RS_UPDATED;
                FUNC_REMOVE: begin
                  rsp_q.status          <= RS_HIT;
                  rsp_q.result_value    <= 32'(r_val);
                  live_q                <= live_q - 1'b1;
                  dead_q                <= dead_q + 1'b1;
                  rsp_q.entry_count     <= 9'(live_q - 1'b1);
                  rsp_q.tombstone_count <= 9'(dead_q + 1'b1);
                end
                default: begin
                  rsp_q.status       <= RS_HIT;
                  rsp_q.result_value <= 32'(r_val);
                end
              endcase
            end else if (func_q == FUNC_INSERT) begin
              rsp_q.status <= RS_FULL;
            end
          end
        end
        ST_INS: begin
          live_q <= live_q + 1'b1;
          dead_q <= tomb_vld_q ? dead_q - 1'b1 : dead_q;
          rsp_q.status          <= RS_INSERTED;
          rsp_q.result_value    <= '0;
          rsp_q.entry_count     <= 9'(live_q + 1'b1);
          rsp_q.tombstone_count <= 9'(tomb_vld_q ? dead_q - 1'b1 : dead_q);
        end
        ST_CLEAR: begin
          idx_q  <= idx_q + 1'b1;
          live_q <= '0;
          dead_q <= '0;
          rsp_q  <= '{status: RS_CLEARED, result_value: '0, entry_count: '0,
                      tombstone_count: '0};
        end
        default: ;
      endcase
    end
  end
endmodule

FILE: bench/tb_top.sv
// testbench for open_addressing_hash_table: random and directed requests against
// a behavioral table predictor held in a small scoreboard class; depends on oaht_pkg and open_addressing_hash_table
`timescale 1ns / 100ps

module tb_top;
  import oaht_pkg::*;

  localparam int unsigned Cap = 256;
  localparam int unsigned LoadLimit = Cap - Cap / 4;

  class table_scoreboard;
    logic [1:0]  st_q [Cap];
    logic [63:0] hash_q [Cap];
    logic [63:0] key_q [Cap];
    logic [3:0]  len_q [Cap];
    logic [31:0] val_q [Cap];
    int unsigned live_n;
    int unsigned dead_n;
    rsp_t        pending_q [$];
    int unsigned mismatches;

    function new();
      wipe();
      mismatches = 0;
    endfunction

    function void wipe();
      for (int i = 0; i < Cap; i++) st_q[i] = SLOT_EMPTY;
      live_n = 0;
      dead_n = 0;
    endfunction

    function logic [63:0] fnv(logic [63:0] k, int unsigned n);
      logic [63:0] h;
      h = FnvBasis;
      for (int i = 0; i < n; i++) begin
        h = h ^ {56'd0, k[8*i +: 8]};
        h = h * FnvPrime;
      end
      return h;
    endfunction

    function int find_slot(logic [63:0] h, logic [63:0] k, logic [3:0] n, bit ins,
                           output bit hit);
      int unsigned idx;
      int tomb;
      idx = h % Cap;
      tomb = -1;
      hit = 0;
      for (int c = 0; c < Cap; c++) begin
        if (st_q[idx] == SLOT_EMPTY) return (ins && tomb >= 0) ? tomb : int'(idx);
        if (st_q[idx] == SLOT_TOMB) begin
          if (tomb < 0) tomb = int'(idx);
        end else if (hash_q[idx] == h && len_q[idx] == n && key_q[idx] == k) begin
          hit = 1;
          return int'(idx);
        end
        idx = (idx + 1) % Cap;
      end
      return ins ? tomb : -1;
    endfunction

    function void note_request(req_t r);
      rsp_t e;
      logic [3:0] n;
      logic [63:0] k;
      logic [63:0] h;
      int idx;
      bit hit;
      n = (r.key_len > 4'd8) ? 4'd8 : r.key_len;
      k = r.key;
      for (int i = 0; i < 8; i++) if (i >= n) k[8*i +: 8] = 8'd0;
      h = fnv(k, n);
      e.status = RS_MISS;
      e.result_value = '0;
      case (func_e'(r.func))
        FUNC_CLEAR: begin
          wipe();
          e.status = RS_CLEARED;
        end
        FUNC_LOOKUP: begin
          idx = find_slot(h, k, n, 0, hit);
          if (hit) begin
            e.status = RS_HIT;
            e.result_value = val_q[idx];
          end
        end
        FUNC_REMOVE: begin
          idx = find_slot(h, k, n, 0, hit);
          if (hit) begin
            e.status = RS_HIT;
            e.result_value = val_q[idx];
            st_q[idx] = SLOT_TOMB;
            live_n--;
            dead_n++;
          end
        end
        default: begin
          idx = find_slot(h, k, n, 0, hit);
          if (hit) begin
            val_q[idx] = r.value;
            e.status = RS_UPDATED;
          end else if (live_n + dead_n + 1 > LoadLimit) begin
            e.status = RS_FULL;
          end else begin
            idx = find_slot(h, k, n, 1, hit);
            if (idx < 0 || hit) begin
              e.status = RS_FULL;
            end else begin
              if (st_q[idx] == SLOT_TOMB) dead_n--;
              st_q[idx] = SLOT_USED;
              hash_q[idx] = h;
              key_q[idx] = k;
              len_q[idx] = n;
              val_q[idx] = r.value;
              live_n++;
              e.status = RS_INSERTED;
            end
          end
        end
      endcase
      e.entry_count = live_n[8:0];
      e.tombstone_count = dead_n[8:0];
      pending_q.push_back(e);
    endfunction

    function void check_result(rsp_t got);
      rsp_t e;
      if (pending_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h", got);
        return;
      end
      e = pending_q.pop_front();
      if (got.status !== e.status || got.result_value !== e.result_value ||
          got.entry_count !== e.entry_count ||
          got.tombstone_count !== e.tombstone_count) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: exp st=%0d val=%h ent=%0d tomb=%0d got st=%0d val=%h %0s",
                   e.status, e.result_value, e.entry_count, e.tombstone_count,
                   got.status, got.result_value,
                   $sformatf("ent=%0d tomb=%0d", got.entry_count, got.tombstone_count));
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  req_t in_data_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  rsp_t out_data_o;

  table_scoreboard sb = new();
  logic [63:0] key_pool [16];
  int unsigned gap_left = 0;
  int unsigned burst_left = 0;

  always #5 clk_i = ~clk_i;

  open_addressing_hash_table DUT (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid_i), .in_ready_o(in_ready_o), .in_data_i(in_data_i),
    .out_valid_o(out_valid_o), .out_ready_i(out_ready_i), .out_data_o(out_data_o)
  );

  // receiver stall pattern: stretches of steady ready, others with random stalls
  int unsigned rx_cnt = 0;
  always @(posedge clk_i) begin
    if (out_valid_o && out_ready_i) sb.check_result(out_data_o);
    rx_cnt <= rx_cnt + 1;
    if (rx_cnt[9:8] == 2'd0) out_ready_i <= 1'b1;
    else if (rx_cnt[9:8] == 2'd1) out_ready_i <= ($urandom_range(0, 3) != 0);
    else out_ready_i <= ($urandom_range(0, 7) > 4);
  end

  task automatic send(input req_t r);
    while (gap_left > 0) begin
      @(posedge clk_i);
      gap_left--;
    end
    in_valid_i <= 1'b1;
    in_data_i <= r;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_request(r);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 12);
      gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 40);
    end
    if (gap_left > 0) in_valid_i <= 1'b0;
  endtask

  task automatic send_op(input func_e f, input logic [63:0] k, input logic [3:0] n,
                         input logic [31:0] v);
    req_t r;
    r.func = f;
    r.key = k;
    r.key_len = n;
    r.value = v;
    send(r);
  endtask

  task automatic drain();
    @(posedge clk_i);
    in_valid_i <= 1'b0;
    while (sb.pending_q.size() != 0) @(posedge clk_i);
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  initial begin
    logic [63:0] k;
    logic [3:0] n;
    int unsigned sel;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    for (int i = 0; i < 16; i++) key_pool[i] = rand64();

    // directed
    send_op(FUNC_LOOKUP, 64'd0, 4'd0, 32'd0);
    send_op(FUNC_INSERT, 64'd0, 4'd0, 32'hFFFF_FFFF);
    send_op(FUNC_LOOKUP, 64'hFFFF_FFFF_FFFF_FFFF, 4'd0, 32'd0);
    send_op(FUNC_INSERT, 64'hFFFF_FFFF_FFFF_FFFF, 4'd8, 32'h1234_5678);
    send_op(FUNC_LOOKUP, 64'hFFFF_FFFF_FFFF_FFFF, 4'd15, 32'd0);
    send_op(FUNC_INSERT, 64'hFFFF_FFFF_FFFF_FFFF, 4'd9, 32'd0);
    send_op(FUNC_INSERT, 64'hAAAA_5555_AAAA_55AB, 4'd1, 32'd7);
    send_op(FUNC_LOOKUP, 64'h0000_0000_0000_00AB, 4'd1, 32'd0);
    send_op(FUNC_LOOKUP, 64'h0000_0000_0000_00AB, 4'd2, 32'd0);
    send_op(FUNC_REMOVE, 64'h1234_0000_0000_00AB, 4'd1, 32'd0);
    send_op(FUNC_REMOVE, 64'h0000_0000_0000_00AB, 4'd1, 32'd0);
    send_op(FUNC_LOOKUP, 64'h0000_0000_0000_00AB, 4'd1, 32'd0);
    send_op(FUNC_INSERT, 64'h0000_0000_0000_00AB, 4'd1, 32'hA5A5_A5A5);
    send_op(FUNC_INSERT, 64'h0102_0304_0506_0708, 4'd4, 32'd1);
    send_op(FUNC_CLEAR, 64'hFFFF_FFFF_FFFF_FFFF, 4'd15, 32'hFFFF_FFFF);
    send_op(FUNC_LOOKUP, 64'd0, 4'd0, 32'd0);
    drain();

    // insert past the load limit of the table, with removes of a key that is not in it
    for (int i = 0; i < 200; i++) begin
      send_op(FUNC_INSERT, rand64(), 4'($urandom_range(1, 8)), $urandom());
      if (i % 10 == 0) send_op(FUNC_REMOVE, key_pool[0], 4'd8, 32'd0);
    end
    send_op(FUNC_INSERT, key_pool[1], 4'd8, 32'd3);
    send_op(FUNC_CLEAR, 64'd0, 4'd0, 32'd0);

    // random, mostly on a small pool of keys so hits and tombstones occur
    for (int i = 0; i < 760; i++) begin
      if (i == 380) drain();
      sel = $urandom_range(0, 99);
      if ($urandom_range(0, 3) != 0) begin
        k = key_pool[4'($urandom_range(0, 15))];
        n = ($urandom_range(0, 3) == 0) ? 4'($urandom_range(0, 15)) : 4'd8;
      end else begin
        k = rand64();
        n = 4'($urandom_range(0, 15));
      end
      if (sel < 35) send_op(FUNC_INSERT, k, n, $urandom());
      else if (sel < 65) send_op(FUNC_LOOKUP, k, n, $urandom());
      else if (sel < 98) send_op(FUNC_REMOVE, k, n, $urandom());
      else send_op(FUNC_CLEAR, k, n, $urandom());
    end
    drain();
    repeat (600) @(posedge clk_i);
    if (sb.mismatches == 0 && sb.pending_q.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  initial begin
    #100ms;
    $display("FAILED: results differ");
    $finish;
  end
endmodule

FILE: filelist.f
design/oaht_pkg.sv
design/oaht_ram.sv
design/open_addressing_hash_table.sv
bench/tb_top.sv
